FILE: rtl/btla_pkg.sv
`timescale 1ns / 1ps

package btla_pkg;

  // Sizing of the frame stores and the label space.
  localparam int MAX_BOXES  = 16;
  localparam int LABELS     = 16;
  localparam int COORD_BITS = 12;

  localparam int SLOT_W   = $clog2(MAX_BOXES);
  localparam int CNT_W    = $clog2(MAX_BOXES + 1);
  localparam int LIDX_W   = $clog2(LABELS);
  localparam int LABEL_W  = $clog2(LABELS + 1);
  localparam int DSLOT_W  = 4;
  localparam int TRACK_W  = 5;

  // Score arithmetic.
  localparam int SCORE_W   = 32;
  localparam int OVL_W     = COORD_BITS + 2;
  localparam int PROD_W    = 2 * COORD_BITS;
  localparam int NUM_W     = PROD_W + 7;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int SCALE     = 100;
  localparam int FLOOR_LIM = 10000;

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic [LABEL_W-1:0]       label_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t SCORE_INIT  = -score_t'(FLOOR_LIM);
  localparam score_t SCORE_FLOOR = -score_t'(FLOOR_LIM + 1);
  localparam label_t NO_LABEL    = label_t'(LABELS);

  // One stored box with its label (tentative or final).
  typedef struct packed {
    coord_t size;
    coord_t y;
    coord_t x;
    label_t label;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAND_RD,
    S_CAND_GO,
    S_CAND_WAIT,
    S_LBL_RD,
    S_LBL_CHK,
    S_STORE,
    S_CLOSE,
    S_DED_RD,
    S_DED_CHK,
    S_ASN_RD,
    S_ASN,
    S_EMIT
  } state_t;

endpackage

FILE: rtl/btla_ifs.sv
`timescale 1ns / 1ps

// Detection channel.
interface btla_det_if import btla_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   req_type;
  coord_t box_x;
  coord_t box_y;
  coord_t box_size;
  logic   last_in_frame;

  modport source (output valid, req_type, box_x, box_y, box_size, last_in_frame,
                  input ready);
  modport sink (input valid, req_type, box_x, box_y, box_size, last_in_frame,
                output ready);
endinterface

// Label result channel.
interface btla_lbl_if import btla_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DSLOT_W-1:0] det_slot;
  logic [TRACK_W-1:0] track_label;
  logic               last_label;

  modport source (output valid, det_slot, track_label, last_label, input ready);
  modport sink (input valid, det_slot, track_label, last_label, output ready);
endinterface

FILE: rtl/box_track_label_association.sv
`timescale 1ns / 1ps
// A detection is scored in turn against each box of the previous frame.
// An overlapping candidate costs a three-stage score pipeline and a 31-step divider.
// A separated one, or any when the new box has zero size, skips the divider.
// Frame close runs a duplicate pass, then emits labels. One transaction is worked at a time.
// Reset (synchronous, rst high) clears counts, label flags and the state machine;
// the box memories are not cleared and are only read below the stored counts.

module box_track_label_association import btla_pkg::*; (
  input logic        clk,
  input logic        rst,
  btla_det_if.sink   det_in,
  btla_lbl_if.source label_out
);

  state_t state, state_next;

  logic [CNT_W-1:0]  cur_count, prev_count;
  logic [SLOT_W-1:0] j, c, k;
  coord_t            bx, by, bs;
  logic              last_pend;
  score_t            best;
  label_t            tent, cand_label;
  logic [LABELS-1:0] used, lvalid;
  logic [MAX_BOXES-1:0] drop;

  logic               out_valid;
  logic [DSLOT_W-1:0] out_slot;
  logic [TRACK_W-1:0] out_label;
  logic               out_last;

  // Memories.
  entry_t prev_mem [MAX_BOXES];
  entry_t cur_mem [MAX_BOXES];
  score_t lbl_mem [LABELS];
  entry_t prev_rd, cur_rd;
  score_t lbl_rd;
  logic [SLOT_W-1:0] cur_raddr;

  logic   acc, out_acc, sc_done, better;
  score_t sc, lbl_cur;
  logic   free_found;
  logic [LIDX_W-1:0] free_idx;
  label_t asn_label;
  logic   need_free;

  assign acc     = det_in.valid && det_in.ready;
  assign out_acc = label_out.valid && label_out.ready;

  // Lowest label not yet taken in this frame.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = LABELS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = LIDX_W'(i);
      end
    end
  end

  always_comb begin
    lbl_cur   = lvalid[tent[LIDX_W-1:0]] ? lbl_rd : SCORE_INIT;
    better    = lbl_cur < best;
    need_free = (cur_rd.label == NO_LABEL) || drop[k];
    asn_label = !need_free ? cur_rd.label : (free_found ? label_t'(free_idx) : NO_LABEL);
    cur_raddr = (state == S_ASN_RD) ? k : c;
  end

  btla_score u_score (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_CAND_GO),
    .cand  (prev_rd),
    .cx    (bx),
    .cy    (by),
    .cs    (bs),
    .done  (sc_done),
    .score (sc)
  );

  // Previous frame memory: read during scoring, written while labels go out.
  always_ff @(posedge clk) begin
    if (state == S_ASN) begin
      prev_mem[k] <= '{size: cur_rd.size, y: cur_rd.y, x: cur_rd.x, label: asn_label};
    end
    prev_rd <= prev_mem[j];
  end

  // Current frame memory.
  always_ff @(posedge clk) begin
    if (state == S_STORE) begin
      cur_mem[cur_count[SLOT_W-1:0]] <= '{size: bs, y: by, x: bx, label: tent};
    end
    cur_rd <= cur_mem[cur_raddr];
  end

  // Best score per label for the frame; entries without a valid flag read as the start value.
  always_ff @(posedge clk) begin
    if (state == S_LBL_CHK && better) begin
      lbl_mem[tent[LIDX_W-1:0]] <= best;
    end
    lbl_rd <= lbl_mem[tent[LIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (det_in.req_type) begin
            state_next = S_CLOSE;
          end else if (cur_count < CNT_W'(MAX_BOXES)) begin
            state_next = (prev_count == '0) ? S_STORE : S_CAND_RD;
          end else if (det_in.last_in_frame) begin
            state_next = S_CLOSE;
          end
        end
      end
      S_CAND_RD:   state_next = S_CAND_GO;
      S_CAND_GO:   state_next = S_CAND_WAIT;
      S_CAND_WAIT: begin
        if (sc_done) begin
          state_next = (CNT_W'(j) + CNT_W'(1) == prev_count) ? S_LBL_RD : S_CAND_RD;
        end
      end
      S_LBL_RD:  state_next = (tent == NO_LABEL) ? S_STORE : S_LBL_CHK;
      S_LBL_CHK: state_next = S_STORE;
      S_STORE:   state_next = last_pend ? S_CLOSE : S_IDLE;
      S_CLOSE:   state_next = (cur_count == '0) ? S_IDLE : S_DED_RD;
      S_DED_RD:  state_next = S_DED_CHK;
      S_DED_CHK: state_next = (c == '0) ? S_ASN_RD : S_DED_RD;
      S_ASN_RD:  state_next = S_ASN;
      S_ASN:     state_next = S_EMIT;
      S_EMIT: begin
        if (out_acc) begin
          state_next = out_last ? S_IDLE : S_ASN_RD;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Control registers and frame bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_count  <= '0;
      prev_count <= '0;
      used       <= '0;
      lvalid     <= '0;
      out_valid  <= 1'b0;
      last_pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc && !det_in.req_type) begin
            last_pend <= det_in.last_in_frame;
          end
        end
        S_LBL_CHK: begin
          if (better) begin
            lvalid[tent[LIDX_W-1:0]] <= 1'b1;
          end
        end
        S_STORE: begin
          cur_count <= cur_count + CNT_W'(1);
        end
        S_CLOSE: begin
          if (cur_count == '0) begin
            prev_count <= '0;
            used       <= '0;
            lvalid     <= '0;
          end
        end
        S_DED_CHK: begin
          if (cur_rd.label != NO_LABEL) begin
            used[cur_rd.label[LIDX_W-1:0]] <= 1'b1;
          end
        end
        S_ASN: begin
          if (need_free && free_found) begin
            used[free_idx] <= 1'b1;
          end
          out_valid <= 1'b1;
        end
        S_EMIT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            if (out_last) begin
              prev_count <= cur_count;
              cur_count  <= '0;
              used       <= '0;
              lvalid     <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (acc) begin
          bx   <= det_in.box_x;
          by   <= det_in.box_y;
          bs   <= det_in.box_size;
          best <= SCORE_INIT;
          tent <= NO_LABEL;
          j    <= '0;
        end
      end
      S_CAND_GO: begin
        cand_label <= prev_rd.label;
      end
      S_CAND_WAIT: begin
        if (sc_done) begin
          if (best < sc) begin
            best <= sc;
            tent <= cand_label;
          end
          j <= j + SLOT_W'(1);
        end
      end
      S_LBL_CHK: begin
        if (!better) begin
          tent <= NO_LABEL;
        end
      end
      S_CLOSE: begin
        c <= SLOT_W'(cur_count - CNT_W'(1));
        k <= '0;
      end
      S_DED_CHK: begin
        drop[c] <= (cur_rd.label != NO_LABEL) && used[cur_rd.label[LIDX_W-1:0]];
        c       <= c - SLOT_W'(1);
      end
      S_ASN: begin
        out_slot  <= DSLOT_W'(k);
        out_label <= TRACK_W'(asn_label);
        out_last  <= CNT_W'(k) + CNT_W'(1) == cur_count;
      end
      S_EMIT: begin
        if (out_acc) begin
          k <= k + SLOT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign det_in.ready          = state == S_IDLE;
  assign label_out.valid       = out_valid;
  assign label_out.det_slot    = out_slot;
  assign label_out.track_label = out_label;
  assign label_out.last_label  = out_last;

  // A label result is offered only from the emit step.
  a_out_in_emit: assert property (@(posedge clk) disable iff (rst)
    label_out.valid |-> state == S_EMIT)
    else $error("label result offered outside emit step");

  // No detection is taken while a label result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    det_in.ready |-> !label_out.valid)
    else $error("detection taken while label pending");

  // The current frame never holds more boxes than its store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cur_count <= CNT_W'(MAX_BOXES))
    else $error("current frame count overflow");

  // A frame close that emits leaves the current frame empty afterwards.
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_acc && out_last) |=> cur_count == '0)
    else $error("current frame not cleared after close");

endmodule

FILE: rtl/btla_div.sv
`timescale 1ns / 1ps

module btla_div import btla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [PROD_W-1:0] den,
  output logic              done,
  output logic [NUM_W-1:0]  quo
);

  logic [PROD_W-1:0]    rem;
  logic [PROD_W-1:0]    den_q;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [PROD_W:0]      trial;
  logic                 fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
      cnt   <= DIV_CNT_W'(NUM_W);
    end else if (busy) begin
      rem <= fits ? PROD_W'(trial - {1'b0, den_q}) : trial[PROD_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

endmodule

FILE: rtl/btla_score.sv
`timescale 1ns / 1ps

module btla_score import btla_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  entry_t cand,
  input  coord_t cx,
  input  coord_t cy,
  input  coord_t cs,
  output logic   done,
  output score_t score
);

  logic              v1, v2, v3;
  logic [OVL_W-1:0]  w, h;
  coord_t            dx, dy, cs1;
  logic              ovl1, ovl2, ovl3, zero1, zero2, zero3;
  logic [PROD_W-1:0] pwh, pd, sq2, sq3;
  logic [NUM_W-1:0]  num;
  score_t            neg;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  quo;
  logic [OVL_W-1:0]  w_c, h_c;

  // Side overlaps; a negative result means the boxes are apart on that axis.
  always_comb begin
    if (cand.x > cx) begin
      w_c = {2'b00, cand.size} - ({2'b00, cand.x} - {2'b00, cx});
    end else begin
      w_c = {2'b00, cs} - ({2'b00, cx} - {2'b00, cand.x});
    end
    if (cand.y > cy) begin
      h_c = {2'b00, cand.size} - ({2'b00, cand.y} - {2'b00, cy});
    end else begin
      h_c = {2'b00, cs} - ({2'b00, cy} - {2'b00, cand.y});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage one: overlaps and absolute offsets.
  always_ff @(posedge clk) begin
    if (start) begin
      w     <= w_c;
      h     <= h_c;
      dx    <= (cand.x > cx) ? cand.x - cx : cx - cand.x;
      dy    <= (cand.y > cy) ? cand.y - cy : cy - cand.y;
      ovl1  <= !w_c[OVL_W-1] && !h_c[OVL_W-1];
      zero1 <= cs == '0;
      cs1   <= cs;
    end
  end

  // Stage two: the three products.
  always_ff @(posedge clk) begin
    if (v1) begin
      pwh   <= w[COORD_BITS-1:0] * h[COORD_BITS-1:0];
      pd    <= dx * dy;
      sq2   <= cs1 * cs1;
      ovl2  <= ovl1;
      zero2 <= zero1;
    end
  end

  // Stage three: scaled dividend and the floored separation score.
  always_ff @(posedge clk) begin
    if (v2) begin
      num   <= NUM_W'(pwh) * NUM_W'(SCALE);
      neg   <= (pd > PROD_W'(FLOOR_LIM)) ? SCORE_FLOOR : 0 - $signed(SCORE_W'(pd));
      sq3   <= sq2;
      ovl3  <= ovl2;
      zero3 <= zero2;
    end
  end

  assign div_start = v3 && ovl3 && !zero3;

  btla_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (sq3),
    .done  (div_done),
    .quo   (quo)
  );

  // Separated candidates, and any candidate when the new box has zero size, finish without the divider.
  assign done  = (v3 && !div_start) || div_done;
  assign score = div_done ? score_t'(quo) : (ovl3 ? '0 : neg);

endmodule
